[design/ffra_pkg.sv]
// shared types and constants for the first-fit rectangle allocator
// no dependencies; imported by ffra_window and first_fit_rect_allocator
package ffra_pkg;

  // configuration register indexes
  localparam logic CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic CFG_ATLAS_HEIGHT = 1'b1;

  // reset value of both atlas size registers
  localparam logic [6:0] ATLAS_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN,
    S_MARK,
    S_RESP
  } state_t;

  // controls for the row window accumulator
  typedef struct packed {
    logic clear;
    logic load;
  } win_ctl_t;

endpackage

[design/ffra_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ffra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ffra_window.sv]
// row window: ors the rows under a candidate band and tests one column span
// depends on ffra_pkg
module ffra_window import ffra_pkg::*; #(
  parameter int W  = 64,
  parameter int XW = 6
) (
  input  logic          clk,
  input  win_ctl_t      ctl,
  input  logic [W-1:0]  rdata,
  input  logic [W-1:0]  span,
  input  logic [XW-1:0] x,
  output logic          fit,
  output logic [W-1:0]  mask
);

  logic [W-1:0] acc;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.load) begin
      acc <= acc | rdata;
    end
  end

  assign mask = span << x;
  assign fit  = ((acc & mask) == '0);

endmodule

[design/first_fit_rect_allocator.sv]
// top level of the first-fit rectangle allocator: sequencer, config registers
// depends on ffra_pkg, ffra_ram, ffra_window
//
// usage
//   request channel: a transaction is taken at a rising edge with start high
//   and busy low; rect_width and rect_height are sampled then. busy stays high
//   until the result has been shown.
//   result channel: done is high for exactly one cycle with found, place_x and
//   place_y valid. the receiver cannot stall; it must take the result then.
//   config channel: cfg_ready is always high; a write of cfg_data to register
//   cfg_index (0 atlas width, 1 atlas height) lands when cfg_valid is high.
//   write config only while busy is low.
// operation
//   the occupancy bitmap sits in one ram, one row per word. every candidate
//   row band ors its h rows through the single read port, then tests one
//   column position per cycle, up to aw-w+1 positions. a hit then
//   read-modify-writes the rows, and the result follows in its own state. a
//   rejected request (zero or oversized) goes straight to the result.
// reset
//   rst clears the config to 64x64, then sweeps all MAX_HEIGHT ram rows to
//   zero, one row per cycle, with busy high; config writes still land.
module first_fit_rect_allocator import ffra_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  // request
  input  logic       start,
  output logic       busy,
  input  logic [6:0] rect_width,
  input  logic [6:0] rect_height,
  // result
  output logic       done,
  output logic       found,
  output logic [5:0] place_x,
  output logic [5:0] place_y,
  // config
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  // row address, column index and row-count widths
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CHW = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = (CHW > 7) ? CHW : 7;

  state_t state, state_next;

  // config registers
  logic [6:0] atlas_width;
  logic [6:0] atlas_height;

  // request context
  logic [6:0]           req_h;
  logic [MAX_WIDTH-1:0] span;
  logic [XW-1:0]        x_last;
  logic [RW-1:0]        y_last;
  logic                 bad;

  // scan position and row pipeline
  logic [XW-1:0] x_cnt;
  logic [RW-1:0] y_cnt;
  logic [6:0]    issued;
  logic          rd_vld;
  logic [RW-1:0] rd_addr;
  logic [RW-1:0] clr_addr;

  // registered result
  logic          res_found;
  logic [XW-1:0] res_x;
  logic [RW-1:0] res_y;

  // mark mask latched on a hit
  logic [MAX_WIDTH-1:0] mbits;

  // effective atlas size, clamped to what was built
  logic [6:0]    aw_eff;
  logic [CW-1:0] ah_eff;
  logic          req_bad;

  // ram ports
  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [MAX_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [RW-1:0]        mem_raddr;
  logic [MAX_WIDTH-1:0] mem_rdata;

  // window
  win_ctl_t             win_ctl;
  logic                 win_fit;
  logic [MAX_WIDTH-1:0] win_mask;

  logic accept;
  logic issue;
  logic band_done;

  assign aw_eff = (atlas_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : atlas_width;
  assign ah_eff = (CW'(atlas_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT)
                                                         : CW'(atlas_height);
  assign req_bad = (rect_width == '0) || (rect_height == '0) ||
                   (rect_width > aw_eff) || (CW'(rect_height) > ah_eff);

  assign accept    = (state == S_IDLE) && start;
  assign issue     = ((state == S_READ) || (state == S_MARK)) && (issued != req_h);
  // all rows of the band have come back from the ram
  assign band_done = (issued == req_h) && !rd_vld;
  assign mem_raddr = RW'(CW'(y_cnt) + CW'(issued));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == RW'(MAX_HEIGHT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = req_bad ? S_RESP : S_READ;
      end
      S_READ: begin
        if (band_done) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (win_fit) begin
          state_next = S_MARK;
        end else if (x_cnt == x_last) begin
          state_next = (y_cnt == y_last) ? S_RESP : S_READ;
        end
      end
      S_MARK: begin
        if (band_done) state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    busy          = 1'b1;
    done          = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = rd_addr;
    mem_wdata     = mem_rdata | mbits;
    mem_re        = issue;
    win_ctl.clear = 1'b0;
    win_ctl.load  = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE: begin
        busy          = 1'b0;
        win_ctl.clear = 1'b1;
      end
      S_READ: begin
        win_ctl.load = rd_vld;
      end
      S_SCAN: begin
        // start a fresh band when moving down a row
        win_ctl.clear = !win_fit && (x_cnt == x_last);
      end
      S_MARK: begin
        mem_we = rd_vld;
      end
      S_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign found     = res_found;
  assign place_x   = 6'(res_x);
  assign place_y   = 6'(res_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      atlas_width  <= ATLAS_RESET;
      atlas_height <= ATLAS_RESET;
      clr_addr     <= '0;
      rd_vld       <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
          CFG_ATLAS_HEIGHT: atlas_height <= cfg_data;
          default:          atlas_width  <= atlas_width;
        endcase
      end
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  // request context and scan counters
  always_ff @(posedge clk) begin
    if (issue) begin
      issued  <= issued + 1'b1;
      rd_addr <= mem_raddr;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_h     <= rect_height;
          span      <= MAX_WIDTH'({MAX_WIDTH{1'b1}} >> (7'(MAX_WIDTH) - rect_width));
          x_last    <= XW'(aw_eff - rect_width);
          y_last    <= RW'(ah_eff - CW'(rect_height));
          bad       <= req_bad;
          x_cnt     <= '0;
          y_cnt     <= '0;
          issued    <= '0;
          res_found <= 1'b0;
          res_x     <= '0;
          res_y     <= '0;
        end
      end
      S_SCAN: begin
        if (win_fit) begin
          mbits     <= win_mask;
          issued    <= '0;
          res_found <= 1'b1;
          res_x     <= x_cnt;
          res_y     <= y_cnt;
        end else if (x_cnt == x_last) begin
          x_cnt  <= '0;
          y_cnt  <= y_cnt + 1'b1;
          issued <= '0;
        end else begin
          x_cnt <= x_cnt + 1'b1;
        end
      end
      default: begin
        x_cnt <= x_cnt;
      end
    endcase
  end

  ffra_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_rows (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ffra_window #(
    .W (MAX_WIDTH),
    .XW(XW)
  ) u_window (
    .clk  (clk),
    .ctl  (win_ctl),
    .rdata(mem_rdata),
    .span (span),
    .x    (x_cnt),
    .fit  (win_fit),
    .mask (win_mask)
  );

  // a marked row is never read back in the cycle it is written
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("ram read and write hit the same row");

  // a miss reports the origin
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !found |-> place_x == 6'd0 && place_y == 6'd0)
    else $error("miss with nonzero position");

  // a rejected request never reaches a hit
  a_bad_miss: assert property (@(posedge clk) disable iff (rst)
    done && bad |-> !found)
    else $error("rejected request reported as found");

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // the block is free right after a result
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("block not idle after result");

endmodule
